// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; the generator core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MMRG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define MMRG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mmrg_pkg.sv -----
`default_nettype none

package mmrg_pkg;

    // Lag table geometry.
    localparam int TBL_DEPTH = 55;
    localparam int TBL_AW    = 6;

    typedef logic [TBL_AW-1:0] tbl_addr_t;
    typedef logic [31:0]       word_t;

    // One cycle's worth of table traffic: one write and two reads.
    typedef struct packed {
        logic      we;
        tbl_addr_t waddr;
        word_t     wdata;
        tbl_addr_t raddr0;
        tbl_addr_t raddr1;
    } tbl_req_t;

    // Generator selection codes.
    localparam logic [2:0] METH_LCG      = 3'd0;
    localparam logic [2:0] METH_TABLE    = 3'd1;
    localparam logic [2:0] METH_XORSHIFT = 3'd2;
    localparam logic [2:0] METH_FIB      = 3'd3;
    localparam logic [2:0] METH_MWC      = 3'd4;
    localparam logic [2:0] METHOD_RESET  = METH_MWC;

    // Register file decode: the register index is paddr[2].
    localparam int   ADDR_W         = 3;
    localparam logic REG_IDX_METHOD = 1'b0;
    localparam logic REG_IDX_SEED   = 1'b1;

    // Arithmetic constants of the generators.
    localparam word_t LCG_MUL      = 32'd2110005341;
    localparam word_t LCG_INC      = 32'd2531011;
    localparam word_t LCG_OUT_MUL  = 32'd445223;
    localparam word_t LCG_SEED_XOR = 32'd123459876;
    localparam word_t SEED_MASK    = 32'd23459876;
    localparam word_t SEED_BASE    = 32'd61803398;
    localparam word_t MWC_SEED_MUL = 32'd123459871;
    localparam word_t MWC_A_MUL    = 32'd36969;
    localparam word_t MWC_B_MUL    = 32'd18000;

    // Tap positions run from 1 to 55; position p lives at address p-1.
    localparam tbl_addr_t LEAD_RESET  = 6'd0;
    localparam tbl_addr_t TRAIL_RESET = 6'd31;
    localparam tbl_addr_t TAP_FIRST   = 6'd1;
    localparam tbl_addr_t TAP_LAST    = 6'd55;

    // Table seeding sequence.
    localparam logic [6:0] SCAT_STEP     = 7'd21;
    localparam logic [6:0] TBL_DEPTH_C7  = 7'd55;
    localparam tbl_addr_t  SCAT_LAST     = 6'd53;
    localparam tbl_addr_t  TBL_TOP_ADDR  = 6'd54;
    localparam tbl_addr_t  MIX_OFS_START = 6'd31;
    localparam logic [1:0] MIX_PASS_LAST = 2'd3;

    // Difference modulo 2^32 with one taken off when the result is negative.
    function automatic word_t sub_corr(word_t x, word_t y);
        word_t d;
        d = x - y;
        return d - {31'b0, d[31]};
    endfunction

    // Next tap position, wrapping from 55 back to 1.
    function automatic tbl_addr_t tap_advance(tbl_addr_t p);
        return (p >= TAP_LAST) ? TAP_FIRST : p + 6'd1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mmrg_table.sv -----
`default_nettype none

// Lag table: 55 words, one write port and two registered read ports.
// Entries never written read as zero through a per-entry valid bit.
module mmrg_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mmrg_pkg::tbl_req_t req,
    output mmrg_pkg::word_t        rdata0,
    output mmrg_pkg::word_t        rdata1
);

    mmrg_pkg::word_t                  table_mem [mmrg_pkg::TBL_DEPTH];
    logic [mmrg_pkg::TBL_DEPTH-1:0]   valid_reg;
    mmrg_pkg::word_t                  q0_reg;
    mmrg_pkg::word_t                  q1_reg;
    logic                             v0_reg;
    logic                             v1_reg;

    // Storage array with registered reads.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            table_mem[req.waddr] <= req.wdata;
        end
        q0_reg <= table_mem[req.raddr0];
        q1_reg <= table_mem[req.raddr1];
        v0_reg <= valid_reg[req.raddr0];
        v1_reg <= valid_reg[req.raddr1];
    end

    // Valid bits give the all-zero contents after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    assign rdata0 = v0_reg ? q0_reg : '0;
    assign rdata1 = v1_reg ? q1_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/multi_mode_random_generator_core.sv -----
`default_nettype none

// Five-method 32-bit random word generator. The method register selects an LCG with a
// scrambled output, a subtractive lagged table generator (55 words, lags 55 and 24),
// a 17/13/5 xorshift, a Fibonacci pair or a dual multiply-with-carry; every accepted
// transaction returns exactly one word, after an optional reseed from the seed register.
// A plain draw runs from acceptance through the draw state back to idle; the draw state
// covers the registered read of the lag table (and keeps apart the two chained
// multiplies of the LCG), and a result waits in the hold state while the output
// register is full. A reseed adds the pre-draw state; the table method first makes 54
// scatter writes and 4 mixing passes of 55 read-then-write steps via its single write port.
// Configuration registers sit at byte address 0 (method) and 4 (seed).
module multi_mode_random_generator_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_reseed,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [31:0]                        m_random_word,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmrg_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAT   = 3'd1;
    localparam logic [2:0] ST_MIX_RD = 3'd2;
    localparam logic [2:0] ST_MIX_WR = 3'd3;
    localparam logic [2:0] ST_PRE    = 3'd4;
    localparam logic [2:0] ST_DRAW   = 3'd5;
    localparam logic [2:0] ST_HOLD   = 3'd6;

    logic [2:0]            state_reg,    state_next;
    logic [2:0]            method_reg;
    mmrg_pkg::word_t       seed_reg;
    mmrg_pkg::word_t       word_a_reg,   word_a_next;
    mmrg_pkg::word_t       word_b_reg,   word_b_next;
    mmrg_pkg::tbl_addr_t   lead_reg,     lead_next;
    mmrg_pkg::tbl_addr_t   trail_reg,    trail_next;
    mmrg_pkg::word_t       mj_reg,       mj_next;
    mmrg_pkg::word_t       mk_reg,       mk_next;
    mmrg_pkg::tbl_addr_t   k_reg,        k_next;
    mmrg_pkg::tbl_addr_t   scat_cnt_reg, scat_cnt_next;
    mmrg_pkg::tbl_addr_t   mix_j_reg,    mix_j_next;
    mmrg_pkg::tbl_addr_t   mix_o_reg,    mix_o_next;
    logic [1:0]            pass_reg,     pass_next;
    mmrg_pkg::word_t       res_reg,      res_next;
    logic                  m_valid_reg,  m_valid_next;
    mmrg_pkg::word_t       m_data_reg,   m_data_next;

    mmrg_pkg::tbl_req_t    tbl_req;
    mmrg_pkg::word_t       tbl_rdata0;
    mmrg_pkg::word_t       tbl_rdata1;
    mmrg_pkg::word_t       tbl_diff;

    logic                  accept;
    logic                  out_free;
    logic                  pre_go;
    logic                  cfg_we;
    mmrg_pkg::word_t       mj_seed;
    mmrg_pkg::word_t       mj_start;
    logic [6:0]            k_sum;
    logic [6:0]            k_wrap;
    mmrg_pkg::tbl_addr_t   lead_adv;
    mmrg_pkg::tbl_addr_t   trail_adv;
    mmrg_pkg::word_t       lcg_step;
    mmrg_pkg::word_t       lcg_out;
    mmrg_pkg::word_t       xs_1;
    mmrg_pkg::word_t       xs_2;
    mmrg_pkg::word_t       xs_3;
    mmrg_pkg::word_t       mwc_a;
    mmrg_pkg::word_t       mwc_b;
    mmrg_pkg::word_t       mwc_out;
    mmrg_pkg::word_t       draw_val;

    // Lag table storage.
    mmrg_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rdata0  (tbl_rdata0),
        .rdata1  (tbl_rdata1)
    );

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= mmrg_pkg::METHOD_RESET;
            seed_reg   <= '0;
        end else if (cfg_we) begin
            unique case (paddr[2])
                mmrg_pkg::REG_IDX_METHOD: method_reg <= pwdata[2:0];
                mmrg_pkg::REG_IDX_SEED:   seed_reg   <= pwdata;
                default:                  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mmrg_pkg::REG_IDX_METHOD: prdata = {29'b0, method_reg};
            mmrg_pkg::REG_IDX_SEED:   prdata = seed_reg;
            default:                  prdata = '0;
        endcase
    end

    // Handshake terms.
    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign pre_go        = (accept && !s_reseed) || (state_reg == ST_PRE);
    assign m_valid       = m_valid_reg;
    assign m_random_word = m_data_reg;

    // Table seeding arithmetic.
    assign mj_seed  = mmrg_pkg::SEED_BASE - (seed_reg ^ mmrg_pkg::SEED_MASK);
    assign mj_start = (mj_seed == '1) ? '0 : mj_seed;
    assign k_sum    = {1'b0, k_reg} + mmrg_pkg::SCAT_STEP;
    assign k_wrap   = (k_sum >= mmrg_pkg::TBL_DEPTH_C7) ? k_sum - mmrg_pkg::TBL_DEPTH_C7
                                                          : k_sum;
    assign tbl_diff = mmrg_pkg::sub_corr(tbl_rdata0, tbl_rdata1);

    // Per-method step logic.
    assign lead_adv  = mmrg_pkg::tap_advance(lead_reg);
    assign trail_adv = mmrg_pkg::tap_advance(trail_reg);
    assign lcg_step  = word_a_reg * mmrg_pkg::LCG_MUL + mmrg_pkg::LCG_INC;
    assign lcg_out   = (word_a_reg >> 3) * mmrg_pkg::LCG_OUT_MUL;
    assign xs_1      = word_a_reg ^ (word_a_reg << 17);
    assign xs_2      = xs_1 ^ (xs_1 >> 13);
    assign xs_3      = xs_2 ^ (xs_2 << 5);
    assign mwc_a     = mmrg_pkg::MWC_A_MUL * {16'b0, word_a_reg[15:0]}
                       + {16'b0, word_a_reg[31:16]};
    assign mwc_b     = mmrg_pkg::MWC_B_MUL * {16'b0, word_b_reg[15:0]}
                       + {16'b0, word_b_reg[31:16]};
    assign mwc_out   = (mwc_a << 16) + mwc_b;

    always_comb begin
        unique case (method_reg)
            mmrg_pkg::METH_LCG:      draw_val = lcg_out;
            mmrg_pkg::METH_TABLE:    draw_val = tbl_diff;
            mmrg_pkg::METH_XORSHIFT: draw_val = xs_3;
            mmrg_pkg::METH_FIB:      draw_val = word_b_reg;
            default:                 draw_val = mwc_out;
        endcase
    end

    // Sequencer: reseed, table scatter and mixing, pre-draw step, draw, result hand-off.
    always_comb begin
        state_next    = state_reg;
        word_a_next   = word_a_reg;
        word_b_next   = word_b_reg;
        lead_next     = lead_reg;
        trail_next    = trail_reg;
        mj_next       = mj_reg;
        mk_next       = mk_reg;
        k_next        = k_reg;
        scat_cnt_next = scat_cnt_reg;
        mix_j_next    = mix_j_reg;
        mix_o_next    = mix_o_reg;
        pass_next     = pass_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        tbl_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_reseed) begin
                        state_next = ST_PRE;
                        unique case (method_reg)
                            mmrg_pkg::METH_LCG: begin
                                word_a_next = seed_reg ^ mmrg_pkg::LCG_SEED_XOR;
                            end
                            mmrg_pkg::METH_TABLE: begin
                                // Position 55 takes the start word made from the seed; scatter follows.
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = mmrg_pkg::TBL_TOP_ADDR;
                                tbl_req.wdata = mj_start;
                                mj_next       = mj_start;
                                mk_next       = 32'd1;
                                k_next        = mmrg_pkg::SCAT_STEP[5:0];
                                scat_cnt_next = '0;
                                state_next    = ST_SCAT;
                            end
                            mmrg_pkg::METH_XORSHIFT: begin
                                word_a_next = seed_reg;
                            end
                            mmrg_pkg::METH_FIB: begin
                                word_a_next = seed_reg;
                                word_b_next = seed_reg;
                            end
                            default: begin
                                word_a_next = seed_reg;
                                word_b_next = (seed_reg ^ mmrg_pkg::SEED_MASK)
                                              * mmrg_pkg::MWC_SEED_MUL;
                            end
                        endcase
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SCAT: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = k_reg - 6'd1;
                tbl_req.wdata = mk_reg;
                mk_next       = mmrg_pkg::sub_corr(mj_reg, mk_reg);
                mj_next       = mk_reg;
                k_next        = k_wrap[5:0];
                if (scat_cnt_reg == mmrg_pkg::SCAT_LAST) begin
                    mix_j_next = '0;
                    mix_o_next = mmrg_pkg::MIX_OFS_START;
                    pass_next  = '0;
                    state_next = ST_MIX_RD;
                end else begin
                    scat_cnt_next = scat_cnt_reg + 6'd1;
                end
            end
            ST_MIX_RD: begin
                tbl_req.raddr0 = mix_j_reg;
                tbl_req.raddr1 = mix_o_reg;
                state_next     = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = mix_j_reg;
                tbl_req.wdata = tbl_diff;
                mix_o_next    = (mix_o_reg == mmrg_pkg::TBL_TOP_ADDR) ? '0
                                                                      : mix_o_reg + 6'd1;
                state_next    = ST_MIX_RD;
                if (mix_j_reg == mmrg_pkg::TBL_TOP_ADDR) begin
                    mix_j_next = '0;
                    if (pass_reg == mmrg_pkg::MIX_PASS_LAST) begin
                        lead_next  = mmrg_pkg::LEAD_RESET;
                        trail_next = mmrg_pkg::TRAIL_RESET;
                        state_next = ST_PRE;
                    end else begin
                        pass_next = pass_reg + 2'd1;
                    end
                end else begin
                    mix_j_next = mix_j_reg + 6'd1;
                end
            end
            ST_PRE: begin
                state_next = ST_DRAW;
            end
            ST_DRAW: begin
                unique case (method_reg)
                    mmrg_pkg::METH_LCG: ;
                    mmrg_pkg::METH_TABLE: begin
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = lead_reg - 6'd1;
                        tbl_req.wdata = tbl_diff;
                    end
                    mmrg_pkg::METH_XORSHIFT: begin
                        word_a_next = xs_3;
                    end
                    mmrg_pkg::METH_FIB: begin
                        word_a_next = word_b_reg;
                        word_b_next = word_a_reg + word_b_reg;
                    end
                    default: begin
                        word_a_next = mwc_a;
                        word_b_next = mwc_b;
                    end
                endcase
                if (out_free) begin
                    m_data_next  = draw_val;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    res_next   = draw_val;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Pre-draw step: LCG state update, or tap advance and table read.
        if (pre_go) begin
            unique case (method_reg)
                mmrg_pkg::METH_LCG: begin
                    word_a_next = lcg_step;
                end
                mmrg_pkg::METH_TABLE: begin
                    lead_next      = lead_adv;
                    trail_next     = trail_adv;
                    tbl_req.raddr0 = lead_adv - 6'd1;
                    tbl_req.raddr1 = trail_adv - 6'd1;
                end
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            word_a_reg  <= '0;
            word_b_reg  <= '0;
            lead_reg    <= mmrg_pkg::LEAD_RESET;
            trail_reg   <= mmrg_pkg::TRAIL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_a_reg  <= word_a_next;
            word_b_reg  <= word_b_next;
            lead_reg    <= lead_next;
            trail_reg   <= trail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers of the seeding sequence and the result path.
    always_ff @(posedge aclk) begin
        mj_reg       <= mj_next;
        mk_reg       <= mk_next;
        k_reg        <= k_next;
        scat_cnt_reg <= scat_cnt_next;
        mix_j_reg    <= mix_j_next;
        mix_o_reg    <= mix_o_next;
        pass_reg     <= pass_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // The trail tap stays 31 positions ahead of the lead tap, modulo 55.
    `MMRG_ASSERT(a_tap_gap, aclk, aresetn, (7'(lead_reg) + 7'd31 == 7'(trail_reg)) || (7'(trail_reg) + 7'd24 == 7'(lead_reg)), "lead and trail taps lost their spacing")

    // Mixing must finish with the taps back at their start positions.
    `MMRG_ASSERT_IMPL(a_mix_end_taps, aclk, aresetn, $past(state_reg) == ST_MIX_WR && state_reg == ST_PRE, lead_reg == mmrg_pkg::LEAD_RESET && trail_reg == mmrg_pkg::TRAIL_RESET, "taps not restored after table seeding")

    // No table write while only waiting or preparing a draw.
    `MMRG_ASSERT_IMPL(a_no_stray_write, aclk, aresetn, state_reg == ST_HOLD || state_reg == ST_PRE, !tbl_req.we, "unexpected lag table write")

    // A held result implies the output register is still occupied.
    `MMRG_ASSERT_IMPL(a_hold_busy, aclk, aresetn, state_reg == ST_HOLD, m_valid_reg, "result held while output register is empty")

endmodule

`default_nettype wire

// ----- test/multi_mode_random_generator_core_tb.sv -----
`timescale 1ns / 100ps

module multi_mode_random_generator_core_tb;

    typedef logic [31:0] word_t;
    typedef logic [mmrg_pkg::ADDR_W-1:0] reg_addr_t;

    // Register byte addresses on the configuration port.
    localparam reg_addr_t ADDR_METHOD = 3'd0;
    localparam reg_addr_t ADDR_SEED   = 3'd4;

    // Generator arithmetic, kept independent of the package.
    localparam word_t K_LCG_MUL   = 32'd2110005341;
    localparam word_t K_LCG_INC   = 32'd2531011;
    localparam word_t K_LCG_OUT   = 32'd445223;
    localparam word_t K_LCG_XOR   = 32'd123459876;
    localparam word_t K_TAB_MASK  = 32'd23459876;
    localparam word_t K_TAB_BASE  = 32'd61803398;
    localparam word_t K_MWC_SEED  = 32'd123459871;
    localparam word_t K_MWC_A     = 32'd36969;
    localparam word_t K_MWC_B     = 32'd18000;
    localparam int    TABLE_LEN   = 55;
    localparam int    SCATTER_STR = 21;
    localparam int    MIX_OFFSET  = 30;
    localparam int    MIX_PASSES  = 4;
    localparam int    TRAIL_START = 31;

    localparam int ITEM_TARGET  = 1600;
    localparam int CALM_FROM    = 1400;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int LONG_HOLD    = 300;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    logic      s_reseed = 1'b0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    word_t     m_random_word;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    reg_addr_t paddr = '0;
    word_t     pwdata = '0;
    word_t     prdata;
    logic      pready;

    multi_mode_random_generator_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_reseed      (s_reseed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a 2 ns period.
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Predicted generator state and its copy of the registers.
    logic [2:0] cfg_method = mmrg_pkg::METHOD_RESET;
    word_t      cfg_seed = '0;
    word_t      gen_table [TABLE_LEN];
    int         gen_lead = 0;
    int         gen_trail = TRAIL_START;
    word_t      gen_a = '0;
    word_t      gen_b = '0;

    // Stimulus and scoreboard storage.
    bit    reseed_queue [$];
    word_t words_due [$];
    int    errors = 0;
    int    items_sent = 0;
    bit    idle_on = 1'b1;
    int    src_gap = 0;
    int    sink_gap = 0;
    int    sink_hold_req = 0;
    int    sink_hold_left = 0;
    int    cycle_count = 0;

    // Difference modulo 2^32, one less when the result reads as negative.
    function automatic word_t fold_diff(word_t x, word_t y);
        word_t d;
        d = x - y;
        if (d[31])
            d = d - 32'd1;
        return d;
    endfunction

    // Tap positions run 1..55 and wrap back to 1.
    function automatic int next_tap(int p);
        return (p + 1 >= TABLE_LEN + 1) ? 1 : p + 1;
    endfunction

    // Scatter the seed through the table, then run the mixing passes.
    function automatic void rebuild_table(word_t seed);
        word_t mj;
        word_t mk;
        int    k;
        mj = K_TAB_BASE - (seed ^ K_TAB_MASK);
        if (mj == 32'hFFFF_FFFF)
            mj = '0;
        gen_table[TABLE_LEN - 1] = mj;
        mk = 32'd1;
        for (int i = 1; i < TABLE_LEN; i++) begin
            k = (SCATTER_STR * i) % TABLE_LEN;
            gen_table[k - 1] = mk;
            mk = fold_diff(mj, mk);
            mj = gen_table[k - 1];
        end
        for (int pass = 0; pass < MIX_PASSES; pass++) begin
            for (int i = 1; i <= TABLE_LEN; i++) begin
                gen_table[i - 1] = fold_diff(gen_table[i - 1],
                                             gen_table[(i + MIX_OFFSET) % TABLE_LEN]);
            end
        end
        gen_lead = 0;
        gen_trail = TRAIL_START;
    endfunction

    // Work out the word that one transaction yields, updating the state.
    function automatic word_t draw_next(bit reseed);
        word_t v;
        if (reseed) begin
            case (cfg_method)
                mmrg_pkg::METH_LCG:      gen_a = cfg_seed ^ K_LCG_XOR;
                mmrg_pkg::METH_TABLE:    rebuild_table(cfg_seed);
                mmrg_pkg::METH_XORSHIFT: gen_a = cfg_seed;
                mmrg_pkg::METH_FIB: begin
                    gen_a = cfg_seed;
                    gen_b = cfg_seed;
                end
                default: begin
                    gen_a = cfg_seed;
                    gen_b = (cfg_seed ^ K_TAB_MASK) * K_MWC_SEED;
                end
            endcase
        end
        case (cfg_method)
            mmrg_pkg::METH_LCG: begin
                gen_a = gen_a * K_LCG_MUL + K_LCG_INC;
                v = (gen_a >> 3) * K_LCG_OUT;
            end
            mmrg_pkg::METH_TABLE: begin
                gen_lead = next_tap(gen_lead);
                gen_trail = next_tap(gen_trail);
                v = fold_diff(gen_table[gen_lead - 1], gen_table[gen_trail - 1]);
                gen_table[gen_lead - 1] = v;
            end
            mmrg_pkg::METH_XORSHIFT: begin
                v = gen_a;
                v = v ^ (v << 17);
                v = v ^ (v >> 13);
                v = v ^ (v << 5);
                gen_a = v;
            end
            mmrg_pkg::METH_FIB: begin
                gen_b = gen_a + gen_b;
                gen_a = gen_b - gen_a;
                v = gen_a;
            end
            default: begin
                gen_a = K_MWC_A * (gen_a & 32'h0000_FFFF) + (gen_a >> 16);
                gen_b = K_MWC_B * (gen_b & 32'h0000_FFFF) + (gen_b >> 16);
                v = (gen_a << 16) + gen_b;
            end
        endcase
        return v;
    endfunction

    // Register write: setup cycle then access cycle; the prediction follows it.
    task automatic write_reg(reg_addr_t addr, word_t data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_METHOD)
            cfg_method = data[2:0];
        else
            cfg_seed = data;
    endtask

    // Wait until every queued transaction has gone in and every word has come out.
    task automatic drain();
        @(negedge aclk);
        while (reseed_queue.size() > 0 || s_valid || words_due.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic offer(bit reseed);
        reseed_queue.push_back(reseed);
        items_sent++;
    endtask

    // Input driver: presents queued transactions with random gaps.
    always @(posedge aclk) begin : item_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                words_due.push_back(draw_next(s_reseed));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (reseed_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_reseed <= reseed_queue.pop_front();
                    if (idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each word and applies back-pressure.
    always @(posedge aclk) begin : result_check
        word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    $error("random_word: expected nothing, actual %h", m_random_word);
                    errors++;
                end else begin
                    want = words_due.pop_front();
                    if (m_random_word !== want) begin
                        $error("random_word: expected %h, actual %h", want, m_random_word);
                        errors++;
                    end
                end
            end
            if (sink_hold_req > 0) begin
                sink_hold_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 6) == 0)
                    sink_gap = $urandom_range(1, 13);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Test sequence: directed cases first, then random phases.
    initial begin : sequence_ctl
        logic [2:0] meth;
        word_t      sd;
        int         n;
        int         one_in;
        int         phase;
        bit         r;
        for (int i = 0; i < TABLE_LEN; i++)
            gen_table[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: multiply with carry from zero, then a reseed from zero.
        offer(1'b0);
        offer(1'b0);
        offer(1'b1);
        drain();

        // Table draws on the untouched table give zeros, then a proper reseed.
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_TABLE));
        offer(1'b0);
        offer(1'b0);
        offer(1'b1);
        offer(1'b0);
        offer(1'b0);
        drain();

        // Seed that makes the scatter start word wrap to all ones and be cleared.
        write_reg(ADDR_SEED, K_TAB_BASE + 32'd1 ^ K_TAB_MASK);
        offer(1'b1);
        offer(1'b0);
        drain();

        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_LCG));
        write_reg(ADDR_SEED, 32'hFFFF_FFFF);
        offer(1'b1);
        offer(1'b0);
        offer(1'b0);
        drain();

        // Xorshift from zero stays at zero.
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_XORSHIFT));
        write_reg(ADDR_SEED, 32'd0);
        offer(1'b1);
        offer(1'b0);
        drain();

        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_FIB));
        write_reg(ADDR_SEED, 32'hFFFF_FFFF);
        offer(1'b1);
        offer(1'b0);
        drain();

        // Out-of-range method codes behave as multiply with carry.
        write_reg(ADDR_METHOD, 32'd5);
        offer(1'b1);
        drain();
        write_reg(ADDR_METHOD, 32'd6);
        offer(1'b0);
        drain();
        write_reg(ADDR_METHOD, 32'd7);
        write_reg(ADDR_SEED, 32'h8000_0000);
        offer(1'b1);
        offer(1'b0);
        drain();

        // Method changes without reseed carry the shared state over.
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_LCG));
        offer(1'b0);
        drain();
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_XORSHIFT));
        offer(1'b0);
        drain();
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_FIB));
        offer(1'b0);
        drain();
        write_reg(ADDR_METHOD, 32'(mmrg_pkg::METH_TABLE));
        offer(1'b0);
        drain();

        // Random phases, each with its own method and seed.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
                meth = 3'($urandom_range(0, 4));
            else
                meth = 3'($urandom_range(5, 7));
            case ($urandom_range(0, 5))
                0: sd = '0;
                1: sd = 32'hFFFF_FFFF;
                default: sd = $urandom;
            endcase
            write_reg(ADDR_METHOD, {29'd0, meth});
            if ($urandom_range(0, 3) != 0)
                write_reg(ADDR_SEED, sd);
            n = $urandom_range(20, 120);
            one_in = (meth == mmrg_pkg::METH_TABLE) ? 40 : 6;
            // Long receiver hold while the sender keeps offering.
            if (phase == 2) begin
                n = 120;
                @(negedge aclk);
                sink_hold_req = LONG_HOLD;
            end
            for (int i = 0; i < n; i++) begin
                if (i == 0)
                    r = ($urandom_range(0, 3) != 0);
                else
                    r = ($urandom_range(1, one_in) == 1);
                offer(r);
                // Sender pause until every outstanding word is back.
                if (phase % 4 == 3 && i == n / 2)
                    drain();
            end
            drain();
            phase++;
        end

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
